[sv/tbrl_pkg.sv]
// Shared types and constants for the token bucket rate limiter.
package tbrl_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0,
    REG_RATE     = 1'b1
  } reg_idx_t;

  localparam int CFG_W      = 16;
  localparam int TENTHS_W   = 16;

  localparam logic [CFG_W-1:0]    DEFAULT_CAP  = 16'd20;
  localparam logic [CFG_W-1:0]    DEFAULT_RATE = 16'd10;
  localparam logic [TENTHS_W-1:0] TENTHS_MAX   = 16'hFFFF;
  localparam logic [TENTHS_W-1:0] GRANT_COST   = 16'd10;
  localparam logic [4:0]          CAP_SCALE    = 5'd10;

  // Elapsed time beyond 2^DELTA_BITS ms, or a product beyond 2^DELTA_BITS,
  // always fills the bucket: 100 * 65535 stays below 2^23.
  localparam int DELTA_BITS  = 23;
  localparam int MUL_W       = DELTA_BITS + CFG_W;

  // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT for every x below 2^23
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
  localparam int QPROD_W     = DELTA_BITS + RECIP_W;
  localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;

  // Refill candidate computed against one possible last refill time
  typedef struct packed {
    logic [DELTA_BITS-1:0] prod;   // elapsed_ms * rate, low bits
    logic                  sat;    // refill reaches capacity for sure
    logic                  first;  // limiter not started
  } cand_t;

endpackage

[sv/tbrl_cfg.sv]
// Configuration registers with derived capacity in tenths and effective rate.
module tbrl_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_addr,
  input  logic [tbrl_pkg::CFG_W-1:0]   cfg_wdata,
  output logic [tbrl_pkg::TENTHS_W-1:0] cap_tenths,
  output logic [tbrl_pkg::CFG_W-1:0]   rate_eff
);
  import tbrl_pkg::*;

  logic [TENTHS_W-1:0] cap_tenths_r;
  logic [TENTHS_W-1:0] cap_tenths_nxt;
  logic [CFG_W-1:0]    rate_eff_r;
  logic [CFG_W-1:0]    rate_eff_nxt;
  logic [CFG_W-1:0]    cap_eff;
  logic [CFG_W+3:0]    cap_scaled;

  // Substitute defaults for zero and clamp capacity in tenths
  always_comb begin
    cap_eff        = (cfg_wdata == '0) ? DEFAULT_CAP : cfg_wdata;
    cap_scaled     = (CFG_W+4)'(cap_eff) * (CFG_W+4)'(CAP_SCALE);
    cap_tenths_nxt = (cap_scaled > (CFG_W+4)'(TENTHS_MAX)) ? TENTHS_MAX
                                                           : cap_scaled[TENTHS_W-1:0];
    rate_eff_nxt   = (cfg_wdata == '0) ? DEFAULT_RATE : cfg_wdata;
  end

  // Capture writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_tenths_r <= TENTHS_W'(DEFAULT_CAP) * TENTHS_W'(CAP_SCALE);
      rate_eff_r   <= DEFAULT_RATE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_CAPACITY: cap_tenths_r <= cap_tenths_nxt;
        REG_RATE:     rate_eff_r   <= rate_eff_nxt;
      endcase
    end
  end

  assign cap_tenths = cap_tenths_r;
  assign rate_eff   = rate_eff_r;

endmodule

[sv/tbrl_refill.sv]
// Input register and refill product stage with two last-refill candidates.
module tbrl_refill #(
  parameter int TIME_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [TIME_BITS-1:0]       in_now,
  input  logic [tbrl_pkg::CFG_W-1:0] rate_eff,
  input  logic [TIME_BITS-1:0]       last_time,
  input  logic                       commit_adv,
  input  logic                       bkt_ready,
  output logic                       s2_valid,
  output logic [TIME_BITS-1:0]       s2_now,
  output tbrl_pkg::cand_t            s2_cand
);
  import tbrl_pkg::*;

  logic                 s1_valid_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 s2_valid_r;
  logic [TIME_BITS-1:0] s2_now_r;
  cand_t                cand_a_r;
  cand_t                cand_b_r;
  logic                 sel_r;
  cand_t                cand_a;
  cand_t                cand_b;
  logic                 s2_ready;
  logic                 s2_fire;
  logic                 s1_move;

  // Elapsed time against one base, clamped, times the rate
  function automatic cand_t build_cand(input logic [TIME_BITS-1:0] now,
                                       input logic [TIME_BITS-1:0] base,
                                       input logic [CFG_W-1:0]     rate);
    logic [TIME_BITS:0]   diff;
    logic [TIME_BITS-1:0] delta;
    logic [MUL_W-1:0]     prod;
    cand_t                c;
    diff    = {1'b0, now} - {1'b0, base};
    delta   = diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
    prod    = MUL_W'(delta[DELTA_BITS-1:0]) * MUL_W'(rate);
    c.sat   = (|delta[TIME_BITS-1:DELTA_BITS]) || (|prod[MUL_W-1:DELTA_BITS]);
    c.prod  = prod[DELTA_BITS-1:0];
    c.first = (base == '0);
    return c;
  endfunction

  // Handshake through the two stages
  assign s2_ready = !s2_valid_r || bkt_ready;
  assign s2_fire  = s2_valid_r && bkt_ready;
  assign s1_move  = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  // Candidate A: the word ahead moves last refill to its own time.
  // Candidate B: last refill stays as committed now.
  assign cand_a = build_cand(s1_now_r, s2_now_r, rate_eff);
  assign cand_b = build_cand(s1_now_r, last_time, rate_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now_r <= in_now;
    end
    if (s1_move) begin
      s2_now_r <= s1_now_r;
      cand_a_r <= cand_a;
      cand_b_r <= cand_b;
      sel_r    <= s2_fire && commit_adv;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_now   = s2_now_r;
  assign s2_cand  = sel_r ? cand_a_r : cand_b_r;

endmodule

[sv/tbrl_bucket.sv]
// Bucket state update, grant decision and result register.
module tbrl_bucket #(
  parameter int TIME_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s2_valid,
  input  logic [TIME_BITS-1:0]          s2_now,
  input  tbrl_pkg::cand_t               s2_cand,
  input  logic [tbrl_pkg::TENTHS_W-1:0] cap_tenths,
  output logic                          bkt_ready,
  output logic                          commit_adv,
  output logic [TIME_BITS-1:0]          last_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_granted,
  output logic [tbrl_pkg::TENTHS_W-1:0] out_left
);
  import tbrl_pkg::*;

  logic [TENTHS_W-1:0]  held_r;
  logic [TENTHS_W-1:0]  held_nxt;
  logic [TIME_BITS-1:0] last_r;
  logic                 out_valid_r;
  logic                 granted_r;
  logic [TENTHS_W-1:0]  left_r;
  logic [QPROD_W-1:0]   q_full;
  logic [QUOT_W-1:0]    add;
  logic [QUOT_W:0]      sum;
  logic [TENTHS_W-1:0]  total;
  logic                 adv;
  logic                 grant;
  logic                 fire;

  assign bkt_ready = !out_valid_r || out_ready;
  assign fire      = s2_valid && bkt_ready;

  // Divide the product by one hundred through the reciprocal
  assign q_full = QPROD_W'(s2_cand.prod) * QPROD_W'(RECIP);
  assign add    = q_full[QPROD_W-1:RECIP_SHIFT];
  assign sum    = (QUOT_W+1)'(held_r) + (QUOT_W+1)'(add);

  // Refill, saturate at capacity, then take one token if held
  always_comb begin
    total = held_r;
    adv   = 1'b0;
    if (s2_cand.first) begin
      total = cap_tenths;
      adv   = 1'b1;
    end else if (s2_cand.sat || (add >= QUOT_W'(cap_tenths))) begin
      total = cap_tenths;
      adv   = 1'b1;
    end else if (add != '0) begin
      adv   = 1'b1;
      total = (sum > (QUOT_W+1)'(cap_tenths)) ? cap_tenths : sum[TENTHS_W-1:0];
    end
    grant    = (total >= GRANT_COST);
    held_nxt = grant ? (total - GRANT_COST) : total;
  end

  assign commit_adv = fire && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        held_r <= held_nxt;
      end
      if (commit_adv) begin
        last_r <= s2_now;
      end
      if (bkt_ready) begin
        out_valid_r <= s2_valid;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (fire) begin
      granted_r <= grant;
      left_r    <= held_nxt;
    end
  end

  assign last_time   = last_r;
  assign out_valid   = out_valid_r;
  assign out_granted = granted_r;
  assign out_left    = left_r;

endmodule

[sv/token_bucket_rate_limiter.sv]
// Top level of the token bucket rate limiter.
//
//   port group   dir   fields (lowest bit first)
//   in_*         in    tdata: now_ms[TIME_BITS-1:0], zero fill to whole bytes
//   out_*        out   tdata: granted[0], tenths_left[16:1], zero fill [23:17]
//   cfg_*        in    addr 0 bucket_capacity, addr 1 refill_rate, 16-bit data
//
// One word per cycle sustained while results are taken as they appear; a word
// passes from the input register through the product stage to the result
// register, where its result waits until taken.
// The cycle rate is set by the bucket stage: reciprocal divide, add, clamp
// and token take feed the bucket register each cycle.
// Reset (synchronous): bucket empty, limiter not started, capacity 20, rate 10.
// A stalled result holds the pipeline; in_tready drops only when all three
// stages are full.
module token_bucket_rate_limiter #(
  parameter int TIME_BITS = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((TIME_BITS+7)/8)*8-1:0]         in_tdata,   // now_ms, zero fill
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [23:0]                            out_tdata,  // granted, tenths_left, zero fill
  input  logic                                   cfg_we,
  input  logic [0:0]                             cfg_addr,
  input  logic [tbrl_pkg::CFG_W-1:0]             cfg_wdata
);
  import tbrl_pkg::*;

  localparam int OUT_PAD = 24 - 1 - TENTHS_W;

  logic [TENTHS_W-1:0]  cap_tenths;
  logic [CFG_W-1:0]     rate_eff;
  logic [TIME_BITS-1:0] last_time;
  logic                 commit_adv;
  logic                 bkt_ready;
  logic                 s2_valid;
  logic [TIME_BITS-1:0] s2_now;
  cand_t                s2_cand;
  logic                 out_granted;
  logic [TENTHS_W-1:0]  out_left;

  tbrl_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cap_tenths (cap_tenths),
    .rate_eff   (rate_eff)
  );

  tbrl_refill #(
    .TIME_BITS (TIME_BITS)
  ) u_refill (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_now     (in_tdata[TIME_BITS-1:0]),
    .rate_eff   (rate_eff),
    .last_time  (last_time),
    .commit_adv (commit_adv),
    .bkt_ready  (bkt_ready),
    .s2_valid   (s2_valid),
    .s2_now     (s2_now),
    .s2_cand    (s2_cand)
  );

  tbrl_bucket #(
    .TIME_BITS (TIME_BITS)
  ) u_bucket (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_valid    (s2_valid),
    .s2_now      (s2_now),
    .s2_cand     (s2_cand),
    .cap_tenths  (cap_tenths),
    .bkt_ready   (bkt_ready),
    .commit_adv  (commit_adv),
    .last_time   (last_time),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_granted (out_granted),
    .out_left    (out_left)
  );

  // Pack the result word
  assign out_tdata = {OUT_PAD'(0), out_left, out_granted};

  // A word leaving the product stage lands in the result register
  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && bkt_ready) |=> out_tvalid)
    else $error("word lost between product stage and result register");

  // A grant always leaves room for the token taken
  a_grant_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_granted) |-> (out_left <= (TENTHS_MAX - GRANT_COST)))
    else $error("granted result with too many tenths left");

  // Last refill time moves only on a committed advance
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(commit_adv)) |-> $stable(last_time))
    else $error("last refill time changed without an advance");

endmodule
